[src/rsdn_pkg.sv]
// Shared types and constants for the descriptor normalizer.
package rsdn_pkg;

  localparam int ELEM_W = 8;
  localparam int SUM_W = 15;
  localparam int ROOT_W = 16;
  localparam int QUO_W = 41;
  localparam int REM_W = SUM_W + 1;
  localparam int RAD_W = QUO_W + 1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_START,
    ST_DIV,
    ST_SQRT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic store;
    logic rd_addr_load;
    logic sel_b_load;
    logic div_start;
    logic div_step;
    logic sqrt_start;
    logic sqrt_step;
    logic latch_a;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic step_done;
    logic last_pair_out;
  } stat_t;

endpackage

[src/rsdn_ram.sv]
// Generic single-port-write, registered-read RAM.
module rsdn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/rsdn_datapath.sv]
// Datapath: pair store, running sum, bit-serial divider and square root.
module rsdn_datapath #(
  parameter int PAIRS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rsdn_pkg::cmd_t                      cmd,
  output rsdn_pkg::stat_t                     stat,
  input  logic [rsdn_pkg::ELEM_W-1:0]         elem_a,
  input  logic [rsdn_pkg::ELEM_W-1:0]         elem_b,
  output logic [rsdn_pkg::ROOT_W-1:0]         root_a,
  output logic [rsdn_pkg::ROOT_W-1:0]         root_b,
  output logic                                overflow,
  output logic                                last_out
);
  import rsdn_pkg::*;

  localparam int AW = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int CW = $clog2(PAIRS + 1);

  logic [CW-1:0]   count;
  logic [SUM_W-1:0] sum;
  logic            dropped;
  logic [AW-1:0]   rd_addr;
  logic [CW-1:0]   rd_idx;
  logic [15:0]     rdata;
  logic            sel_b;
  logic [ELEM_W-1:0] v;

  logic [QUO_W-1:0] quo;
  logic [REM_W-1:0] rem;
  logic [5:0]       cnt;
  logic [RAD_W-1:0] rad;
  logic [ROOT_W:0]  res;
  logic [RAD_W-1:0] srem;
  logic [ROOT_W-1:0] hold_a;

  logic full;
  assign full = (count == CW'(PAIRS));

  rsdn_ram #(.WIDTH(16), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(cmd.store && !full), .waddr(count[AW-1:0]),
    .wdata({elem_b, elem_a}), .raddr(rd_addr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
      sum <= '0;
      dropped <= 1'b0;
    end else if (cmd.store) begin
      if (full) begin
        dropped <= 1'b1;
      end else begin
        count <= count + 1'b1;
        sum <= sum + SUM_W'(elem_a) + SUM_W'(elem_b);
      end
    end
  end

  // The first element's root is kept when the second element's divide starts.
  always_ff @(posedge clk) begin
    if (cmd.rd_addr_load) begin
      rd_idx <= '0;
      rd_addr <= '0;
    end else if (cmd.emit) begin
      rd_idx <= rd_idx + 1'b1;
      rd_addr <= rd_addr + 1'b1;
    end
    if (cmd.sel_b_load) begin
      sel_b <= 1'b0;
    end else if (cmd.latch_a) begin
      sel_b <= 1'b1;
    end
    if (cmd.div_start && sel_b) begin
      hold_a <= (res > 17'hFFFF) ? 16'hFFFF : res[ROOT_W-1:0];
    end
  end

  assign v = sel_b ? rdata[15:8] : rdata[7:0];

  // Restoring divider, one quotient bit per cycle; then a digit-by-digit
  // square root, one result bit per cycle.
  logic [REM_W-1:0] rtry, rem_next;
  logic [QUO_W-1:0] quo_next;
  logic [RAD_W-1:0] strial, sx;
  logic [RAD_W-1:0] resw;
  always_comb begin
    rtry = {rem[REM_W-2:0], quo[QUO_W-1]};
    if (rtry >= REM_W'(sum)) begin
      rem_next = rtry - REM_W'(sum);
      quo_next = {quo[QUO_W-2:0], 1'b1};
    end else begin
      rem_next = rtry;
      quo_next = {quo[QUO_W-2:0], 1'b0};
    end
    resw = RAD_W'(res);
    sx = {srem[RAD_W-3:0], rad[RAD_W-1:RAD_W-2]};
    strial = {resw[RAD_W-3:0], 2'b01};
  end

  // The root is set up on the last divide step from the final quotient.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo <= {1'b0, v, 32'd0};
      rem <= '0;
      cnt <= 6'(QUO_W);
    end else if (cmd.div_step) begin
      rem <= rem_next;
      quo <= quo_next;
      if (cmd.sqrt_start) begin
        rad <= (sum == '0) ? '0 : {1'b0, quo_next};
        srem <= '0;
        res <= '0;
        cnt <= 6'(RAD_W / 2);
      end else begin
        cnt <= cnt - 1'b1;
      end
    end else if (cmd.sqrt_step) begin
      if (sx >= strial) begin
        srem <= sx - strial;
        res <= {res[ROOT_W-1:0], 1'b1};
      end else begin
        srem <= sx;
        res <= {res[ROOT_W-1:0], 1'b0};
      end
      rad <= {rad[RAD_W-3:0], 2'b00};
      cnt <= cnt - 1'b1;
    end
  end

  assign stat.step_done = (cnt == 6'd1);
  assign stat.last_pair_out = (rd_idx + 1'b1 == count);

  always_comb begin
    root_a = hold_a;
    root_b = (res > 17'hFFFF) ? 16'hFFFF : res[ROOT_W-1:0];
    overflow = dropped;
    last_out = stat.last_pair_out;
  end
endmodule

[src/rsdn_ctrl.sv]
// Controller state machine sequencing load, divide, square root and emit.
module rsdn_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            last_pair,
  input  rsdn_pkg::stat_t stat,
  output rsdn_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            strobe
);
  import rsdn_pkg::*;

  state_t state, state_next;
  logic closing;
  logic on_b;

  assign closing = (state == ST_LOAD) && start && last_pair;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:  if (closing) state_next = ST_READ;
      ST_READ:  state_next = ST_START;
      ST_START: state_next = ST_DIV;
      ST_DIV:   if (stat.step_done) state_next = ST_SQRT;
      ST_SQRT:  if (stat.step_done) state_next = on_b ? ST_EMIT : ST_START;
      ST_EMIT:  state_next = stat.last_pair_out ? ST_LOAD : ST_READ;
      default:  state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || state == ST_READ) begin
      on_b <= 1'b0;
    end else if (state == ST_SQRT && stat.step_done) begin
      on_b <= 1'b1;
    end
  end

  always_comb begin
    cmd = '0;
    busy = (state != ST_LOAD);
    strobe = 1'b0;
    unique case (state)
      ST_LOAD: begin
        cmd.store = start;
        cmd.rd_addr_load = 1'b1;
      end
      ST_READ: begin
        cmd.sel_b_load = 1'b1;
      end
      ST_START: begin
        cmd.div_start = 1'b1;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.sqrt_start = stat.step_done;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (stat.step_done && !on_b) begin
          cmd.latch_a = 1'b1;
        end
      end
      ST_EMIT: begin
        strobe = 1'b1;
        cmd.emit = 1'b1;
        cmd.clear = stat.last_pair_out;
      end
      default: ;
    endcase
  end
endmodule

[src/rootsift_descriptor_normalizer.sv]
// Top level of the descriptor normalizer: controller plus datapath.
// Non-final beats are stored while busy stays low.
// After the closing beat each stored pair goes through a store read, two
// divides with their start states, two roots and one emit state, all on
// the shared serial units; busy is high throughout.
// Results appear one per pair with strobe high for one cycle; the receiver
// cannot stall. Synchronous reset empties the descriptor buffer state.
module rootsift_descriptor_normalizer #(
  parameter int PAIRS_PER_DESC = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  elem_a,
  input  logic [7:0]  elem_b,
  input  logic        last_pair,
  output logic        strobe,
  output logic [15:0] root_a,
  output logic [15:0] root_b,
  output logic        overflow,
  output logic        last_out
);
  import rsdn_pkg::*;

  // The controller issues commands; the datapath reports counter status.
  cmd_t  cmd;
  stat_t stat;

  rsdn_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .last_pair(last_pair),
    .stat(stat), .cmd(cmd), .busy(busy), .strobe(strobe)
  );

  rsdn_datapath #(.PAIRS(PAIRS_PER_DESC)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .elem_a(elem_a), .elem_b(elem_b),
    .root_a(root_a), .root_b(root_b),
    .overflow(overflow), .last_out(last_out)
  );
endmodule
